// File: rtl/htls_pkg.sv
// Package for hex_token_line_stats: widths, character codes, parse modes
// and the byte classification functions.
// No dependencies; rtl/hex_token_line_stats.sv uses it by scoped names.
package htls_pkg;

    // Widths of the word value and the line count registers
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    // Widths of the result fields
    localparam int OUT_COUNT_BITS = 16;
    localparam int OUT_SUM_BITS   = 48;
    localparam int OUT_MAX_BITS   = 32;

    // Working widths: adder with carry, and extensions before the field masks
    localparam int ADD_BITS   = ((VALUE_BITS > OUT_SUM_BITS) ? VALUE_BITS : OUT_SUM_BITS) + 1;
    localparam int CEXT_BITS  = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
    localparam int VEXT_BITS  = (VALUE_BITS > OUT_MAX_BITS) ? VALUE_BITS : OUT_MAX_BITS;

    localparam logic [OUT_SUM_BITS-1:0] SUM_MAX   = {OUT_SUM_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0]   VALUE_MAX = {VALUE_BITS{1'b1}};

    // Item kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    // Word parse modes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HEX    = 2'd1,
        MODE_BAD    = 2'd2,
        MODE_HEXSAT = 2'd3
    } mode_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NL) ||
               (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
    endfunction

    function automatic hex_digit_t hex_digit(input logic [7:0] b);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if ((b >= CHAR_0) && (b <= CHAR_9))
        begin
            d.value = 4'(b - CHAR_0);
        end
        else if ((b >= CHAR_LA) && (b <= CHAR_LF))
        begin
            d.value = 4'(b - CHAR_LA + 8'd10);
        end
        else if ((b >= CHAR_UA) && (b <= CHAR_UF))
        begin
            d.value = 4'(b - CHAR_UA + 8'd10);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: rtl/hex_token_line_stats.sv
// Top level of hex_token_line_stats: per-line count, sum and maximum of hex words.
// Depends on rtl/htls_pkg.sv.
//
// Path: a line-closing beat passes the input register, then the result register.
// Throughput: one input beat per clock while the result beat is not stalled; the word
//   and line registers load from the input register, with the result register after them.
// Reset: rst_n clears the parse mode, word and line registers and both valid flags.
module hex_token_line_stats (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  text_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] number_count,
    output logic [47:0] number_sum,
    output logic [31:0] number_max,
    output logic        value_saturated
);

    localparam int VB = htls_pkg::VALUE_BITS;
    localparam int CB = htls_pkg::COUNT_BITS;
    localparam int AB = htls_pkg::ADD_BITS;

    // Input register
    logic       in_full_reg,  in_full_next;
    logic       kind_reg;
    logic [7:0] byte_reg;

    // Parse and line state
    htls_pkg::mode_t mode_reg, mode_next;
    logic [VB-1:0]   word_reg, word_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [47:0]     sum_reg, sum_next;
    logic [VB-1:0]   max_reg, max_next;
    logic            has_bytes_reg, has_bytes_next;
    logic            clamped_reg, clamped_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] count_out_reg;
    logic [47:0] sum_out_reg;
    logic [31:0] max_out_reg;
    logic        sat_out_reg;

    logic advance;
    logic emit;

    // Line statistics with the pending word folded in
    logic            word_open;
    logic [CB-1:0]   c_count;
    logic [47:0]     c_sum;
    logic [VB-1:0]   c_max;
    logic            c_clamped;
    logic [AB-1:0]   sum_wide;
    htls_pkg::hex_digit_t digit;

    logic [htls_pkg::CEXT_BITS-1:0] count_ext;
    logic [htls_pkg::VEXT_BITS-1:0] max_ext;

    // Process the held byte when the result slot is free or being drained
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && !in_stall)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg <= kind;
            byte_reg <= text_byte;
        end
    end

    // Close the pending word: saturating count, clamped sum, running maximum
    always_comb
    begin
        word_open = (mode_reg == htls_pkg::MODE_HEX) || (mode_reg == htls_pkg::MODE_HEXSAT);
        sum_wide  = AB'(sum_reg) + AB'(word_reg);
        c_count   = count_reg;
        c_sum     = sum_reg;
        c_max     = max_reg;
        c_clamped = clamped_reg;
        if (word_open)
        begin
            if (count_reg != htls_pkg::COUNT_MAX)
            begin
                c_count = count_reg + 1'b1;
            end
            if (sum_wide > AB'(htls_pkg::SUM_MAX))
            begin
                c_sum = htls_pkg::SUM_MAX;
            end
            else
            begin
                c_sum = sum_wide[47:0];
            end
            if (word_reg > max_reg)
            begin
                c_max = word_reg;
            end
            if (mode_reg == htls_pkg::MODE_HEXSAT)
            begin
                c_clamped = 1'b1;
            end
        end
    end

    assign digit = htls_pkg::hex_digit(byte_reg);

    // Next state of the parser and line registers
    always_comb
    begin
        mode_next      = mode_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        has_bytes_next = has_bytes_reg;
        clamped_next   = clamped_reg;
        emit           = 1'b0;
        if (advance)
        begin
            if ((kind_reg == htls_pkg::KIND_END) || (byte_reg == htls_pkg::CHAR_NL))
            begin
                // End of line or text: emit (text end only if the line has bytes), clear
                emit           = (kind_reg == htls_pkg::KIND_TEXT) || has_bytes_reg;
                mode_next      = htls_pkg::MODE_IDLE;
                word_next      = '0;
                count_next     = '0;
                sum_next       = '0;
                max_next       = '0;
                has_bytes_next = 1'b0;
                clamped_next   = 1'b0;
            end
            else if (htls_pkg::is_blank(byte_reg))
            begin
                has_bytes_next = 1'b1;
                mode_next      = htls_pkg::MODE_IDLE;
                word_next      = '0;
                count_next     = c_count;
                sum_next       = c_sum;
                max_next       = c_max;
                clamped_next   = c_clamped;
            end
            else if (!digit.valid)
            begin
                has_bytes_next = 1'b1;
                mode_next      = htls_pkg::MODE_BAD;
                word_next      = '0;
            end
            else
            begin
                has_bytes_next = 1'b1;
                unique case (mode_reg)
                    htls_pkg::MODE_IDLE:
                    begin
                        mode_next = htls_pkg::MODE_HEX;
                        word_next = VB'(digit.value);
                    end
                    htls_pkg::MODE_HEX:
                    begin
                        // Clamp when the next digit would shift bits out of the word
                        if (word_reg[VB-1:VB-4] != 4'd0)
                        begin
                            mode_next = htls_pkg::MODE_HEXSAT;
                            word_next = htls_pkg::VALUE_MAX;
                        end
                        else
                        begin
                            word_next = {word_reg[VB-5:0], digit.value};
                        end
                    end
                    htls_pkg::MODE_BAD, htls_pkg::MODE_HEXSAT:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= htls_pkg::MODE_IDLE;
            word_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            has_bytes_reg <= 1'b0;
            clamped_reg   <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            word_reg      <= word_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            has_bytes_reg <= has_bytes_next;
            clamped_reg   <= clamped_next;
        end
    end

    // Result register: load on emit, drop once the beat is taken
    assign count_ext = htls_pkg::CEXT_BITS'(c_count);
    assign max_ext   = htls_pkg::VEXT_BITS'(c_max);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            count_out_reg <= count_ext[15:0];
            sum_out_reg   <= c_sum;
            max_out_reg   <= max_ext[31:0];
            sat_out_reg   <= c_clamped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign number_count    = count_out_reg;
    assign number_sum      = sum_out_reg;
    assign number_max      = max_out_reg;
    assign value_saturated = sat_out_reg;

    // A newline always yields a result beat
    a_newline_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg == htls_pkg::KIND_TEXT) && (byte_reg == htls_pkg::CHAR_NL))
        |=> out_valid)
        else $error("newline did not produce a result beat");

    // End of text returns the line to its reset state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg == htls_pkg::KIND_END))
        |=> ((mode_reg == htls_pkg::MODE_IDLE) && (count_reg == '0) && (sum_reg == '0)
             && !has_bytes_reg && !clamped_reg))
        else $error("end of text left line state behind");

    // A clamped word holds the all-ones value
    a_hexsat_word: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == htls_pkg::MODE_HEXSAT) |-> (word_reg == htls_pkg::VALUE_MAX))
        else $error("clamped word does not hold the maximum value");

    // No counted word means no sum, no maximum and no clamp flag
    a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((sum_reg == '0) && (max_reg == '0) && !clamped_reg))
        else $error("line statistics without a counted word");

    // A result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
        else $error("result beat overwritten while stalled");

endmodule
